FILE: rtl/swm_pkg.sv
// Shared constants for the sliding-window median filter.
// Depends on nothing; imported by sliding_window_median_top.
package swm_pkg;

  // Sample value range and window depth.
  localparam int VALUE_BITS = 16;
  localparam int MAX_WINDOW = 4096;

  // Fixed port widths.
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_BITS    = 13;

  // Derived sizes of the count tree and the sample ring.
  localparam int NODE_BITS  = VALUE_BITS + 1;
  localparam int TREE_NODES = 2 ** NODE_BITS;
  localparam int PTR_BITS   = $clog2(MAX_WINDOW);
  localparam int WIN_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int CNT_BITS   = WIN_BITS;
  localparam int UPD_BITS   = $clog2(VALUE_BITS + 2);

endpackage

FILE: rtl/sliding_window_median_top.sv
// Sliding-window lower-median filter, top level.
// Depends on swm_pkg and swm_ram (sample ring and count tree memories).
//
// Usage:
// Samples arrive on a valid/ready channel (sample_valid, sample_ready, sample).
// Medians leave on a valid/ready channel (median_valid, median_ready, median).
// The window size is written through cfg_we/cfg_wdata while the block is idle;
// zero acts as one and values above the ring depth saturate to it. A write
// empties the window. The block keeps a histogram of the window as a count
// tree in one memory and a ring of recent samples in another.
// A sample is taken only once the previous one is done: an insert and a removal,
// each a read-modify-write sweep of VALUE_BITS+1 tree levels through the single
// tree port, a root-to-leaf walk of VALUE_BITS levels with a read state and a
// compare state per level, and a state that loads the output register before
// the return to idle. While the window fills the removal sweep is skipped.
// One median is given per sample from the window_size-th sample on.
// After reset and after every window_size write, the tree is cleared by a pass
// over all 2^(VALUE_BITS+1) = 131072 nodes, during which sample_ready stays low.
// A finished median waits in an output register; if the receiver stalls, the
// next sample is still taken and its median is held until the register frees.
module sliding_window_median_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [swm_pkg::CFG_BITS-1:0]  cfg_wdata,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic [swm_pkg::SAMPLE_BITS-1:0] sample,
  output logic                          median_valid,
  input  logic                          median_ready,
  output logic [swm_pkg::SAMPLE_BITS-1:0] median
);

  import swm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CLEAR    = 7'b0000010,
    S_INSERT   = 7'b0000100,
    S_REMOVE   = 7'b0001000,
    S_WALK_RD  = 7'b0010000,
    S_WALK_CMP = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [NODE_BITS-1:0]  clr_addr;
  logic [WIN_BITS-1:0]   weff;
  logic [PTR_BITS-1:0]   wp;
  logic [WIN_BITS-1:0]   fill;
  logic [VALUE_BITS-1:0] v_reg;
  logic [VALUE_BITS-1:0] old_val;
  logic [PTR_BITS-1:0]   p_reg;
  logic                  do_remove;
  logic                  do_out;
  logic [NODE_BITS-1:0]  upd_node;
  logic [NODE_BITS-1:0]  upd_prev;
  logic [UPD_BITS-1:0]   upd_cnt;
  logic [CNT_BITS-1:0]   k_reg;
  logic [NODE_BITS-1:0]  walk_n;
  logic [VALUE_BITS-1:0] res;

  // Memory ports.
  logic                  ring_we;
  logic [PTR_BITS-1:0]   ring_raddr;
  logic [VALUE_BITS-1:0] ring_rdata;
  logic                  tree_we;
  logic [NODE_BITS-1:0]  tree_waddr;
  logic [CNT_BITS-1:0]   tree_wdata;
  logic [NODE_BITS-1:0]  tree_raddr;
  logic [CNT_BITS-1:0]   tree_rdata;

  // Per-sample bookkeeping, evaluated at the input transfer.
  logic                  accept;
  logic [PTR_BITS-1:0]   p_cur;
  logic [WIN_BITS-1:0]   p_inc;
  logic [PTR_BITS-1:0]   wp_after;
  logic                  full;
  logic [WIN_BITS-1:0]   fill_after;
  logic [WIN_BITS:0]     w_plus;
  logic [VALUE_BITS-1:0] v_in;
  logic [WIN_BITS-1:0]   weff_cfg;

  // Tree update and walk helpers.
  logic                  upd_last;
  logic [CNT_BITS-1:0]   delta;
  logic                  go_right;
  logic [NODE_BITS-1:0]  walk_child;
  logic                  out_free;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign out_free     = !median_valid || median_ready;
  assign v_in         = VALUE_BITS'(sample);

  // Ring slot of this sample and the slot after it.
  always_comb begin
    p_cur      = (WIN_BITS'(wp) >= weff) ? '0 : wp;
    p_inc      = WIN_BITS'(p_cur) + WIN_BITS'(1);
    wp_after   = (p_inc >= weff) ? '0 : PTR_BITS'(p_inc);
    full       = (fill >= weff);
    fill_after = full ? fill : fill + WIN_BITS'(1);
    w_plus     = {1'b0, weff} + (WIN_BITS + 1)'(1);
  end

  // Effective window size from a configuration write.
  always_comb begin
    if (cfg_wdata == '0) begin
      weff_cfg = WIN_BITS'(1);
    end else if (32'(cfg_wdata) > MAX_WINDOW) begin
      weff_cfg = WIN_BITS'(MAX_WINDOW);
    end else begin
      weff_cfg = WIN_BITS'(cfg_wdata);
    end
  end

  // Update sweep: read one level per cycle, write back the previous level.
  assign upd_last   = (upd_cnt == UPD_BITS'(VALUE_BITS + 1));
  assign delta      = (state == S_INSERT) ? CNT_BITS'(1) : '1;

  // Walk step: go right when the left subtree holds fewer than k values.
  assign go_right   = (tree_rdata < k_reg);
  assign walk_child = {walk_n[NODE_BITS-2:0], go_right};

  // Memory address and data selection.
  always_comb begin
    ring_raddr = p_cur;
    ring_we    = (state == S_INSERT) && (upd_cnt == '0);
    tree_we    = 1'b0;
    tree_waddr = upd_prev;
    tree_wdata = tree_rdata + delta;
    tree_raddr = upd_node;
    unique case (state)
      S_CLEAR: begin
        tree_we    = 1'b1;
        tree_waddr = clr_addr;
        tree_wdata = '0;
      end
      S_INSERT, S_REMOVE: begin
        tree_we = (upd_cnt != '0);
      end
      S_WALK_RD: begin
        tree_raddr = {walk_n[NODE_BITS-2:0], 1'b0};
      end
      S_IDLE, S_WALK_CMP, S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_INSERT;
      end
      S_CLEAR: begin
        if (clr_addr == '1) state_next = S_IDLE;
      end
      S_INSERT: begin
        if (upd_last) begin
          if (do_remove)   state_next = S_REMOVE;
          else if (do_out) state_next = S_WALK_RD;
          else             state_next = S_IDLE;
        end
      end
      S_REMOVE: begin
        if (upd_last) state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        state_next = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        state_next = walk_child[VALUE_BITS] ? S_EMIT : S_WALK_RD;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Control state; a configuration write empties the window and restarts the clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      weff         <= WIN_BITS'(1);
      wp           <= '0;
      fill         <= '0;
      median_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        median_valid <= 1'b1;
      end else if (median_valid && median_ready) begin
        median_valid <= 1'b0;
      end
      if (cfg_we) begin
        state    <= S_CLEAR;
        clr_addr <= '0;
        weff     <= weff_cfg;
        wp       <= '0;
        fill     <= '0;
      end else begin
        state <= state_next;
        if (state == S_CLEAR) begin
          clr_addr <= clr_addr + NODE_BITS'(1);
        end
        if (accept) begin
          wp   <= wp_after;
          fill <= fill_after;
        end
      end
    end
  end

  // Datapath registers for the item in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      v_reg     <= v_in;
      p_reg     <= p_cur;
      do_remove <= full;
      do_out    <= (fill_after >= weff);
      k_reg     <= CNT_BITS'(w_plus >> 1);
      upd_node  <= {1'b1, v_in};
      upd_cnt   <= '0;
      walk_n    <= NODE_BITS'(1);
    end
    if (state == S_INSERT || state == S_REMOVE) begin
      upd_prev <= upd_node;
      if (upd_last) begin
        upd_node <= {1'b1, old_val};
        upd_cnt  <= '0;
      end else begin
        upd_node <= upd_node >> 1;
        upd_cnt  <= upd_cnt + UPD_BITS'(1);
      end
    end
    // The oldest sample comes out of the ring in the first insert cycle.
    if (state == S_INSERT && upd_cnt == '0) begin
      old_val <= ring_rdata;
    end
    if (state == S_WALK_CMP) begin
      walk_n <= walk_child;
      if (go_right) begin
        k_reg <= k_reg - tree_rdata;
      end
      res <= walk_child[VALUE_BITS-1:0];
    end
    if (state == S_EMIT && out_free) begin
      median <= SAMPLE_BITS'(res);
    end
  end

  // Ring of the most recent samples.
  swm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (p_reg),
    .wdata (v_reg),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // Count tree: node 1 is the root, leaves start at 2^VALUE_BITS.
  swm_ram #(
    .WIDTH (CNT_BITS),
    .DEPTH (TREE_NODES)
  ) u_tree (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tree_rdata)
  );

  // The fill level and the ring pointer never pass the window size.
  assert property (@(posedge clk) disable iff (rst)
    (fill <= weff) && (WIN_BITS'(wp) < weff))
    else $error("fill level or ring pointer beyond the window size");

  // A walk always looks for a rank of at least one.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_RD) |-> (k_reg != '0))
    else $error("median walk with a zero rank");

  // A median is only produced for an item that completes a full window.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_RD) |-> (do_out && fill == weff))
    else $error("median walk while the window is not full");

  // New samples are refused while the tree is being cleared.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !sample_ready)
    else $error("sample taken during the tree clear");

endmodule

FILE: rtl/swm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing; used for the sample ring and the count tree.
module swm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read of the address being written returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
